// ===== rtl/sorted_table_bounded_insert_defines.svh =====
// Assertion macros for the sorted table insert block.
`ifndef SORTED_TABLE_BOUNDED_INSERT_DEFINES_SVH
`define SORTED_TABLE_BOUNDED_INSERT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define STBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stbi_pkg.sv =====
// Shared types and constants for the sorted table insert block.
package stbi_pkg;

  localparam int VALUE_W = 32;
  localparam int BOUND_W = 6;

  // Per-cell write control from the sequencer.
  typedef struct packed {
    logic load;      // cell takes a new entry this cycle
    logic take_new;  // new entry is the inserted word, else the lower neighbor
  } cell_ctl_t;

endpackage

// ===== rtl/stbi_cell.sv =====
// One table cell: holds an entry, compares it and shifts from its lower neighbor.
module stbi_cell (
  input  logic                                 clk,
  input  stbi_pkg::cell_ctl_t                  ctl,
  input  logic signed [stbi_pkg::VALUE_W-1:0]  new_word,
  input  logic signed [stbi_pkg::VALUE_W-1:0]  prev_entry,
  output logic signed [stbi_pkg::VALUE_W-1:0]  entry,
  output logic                                 less
);

  logic signed [stbi_pkg::VALUE_W-1:0] entry_r;
  logic signed [stbi_pkg::VALUE_W-1:0] entry_nxt;

  // Pick the inserted word or the neighbor's entry
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.load) begin
      entry_nxt = ctl.take_new ? new_word : prev_entry;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign less  = entry_r < new_word;

endmodule

// ===== rtl/sorted_table_bounded_insert.sv =====
// Top level: row of table cells with a bisection sequencer.
// From accept to out_valid: a full table is reported in the cycle after accept; an empty
// table goes through the write state; else s bisection steps (at most clog2(TABLE_DEPTH)),
// one a cycle over the compare bits, precede the write state; busy is high meanwhile.
// One item at a time: the next item is taken in the cycle its predecessor's result shows.
// Synchronous active-low reset empties the table; entry words are not cleared.
module sorted_table_bounded_insert #(
  parameter int TABLE_DEPTH = 64,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [stbi_pkg::VALUE_W-1:0] in_new_value,
  input  logic [stbi_pkg::BOUND_W-1:0]        in_search_bound,
  input  logic                                in_start_new,
  output logic                                out_valid,
  output logic [CW-1:0]                       out_insert_position,
  output logic [CW-1:0]                       out_entry_count,
  output logic                                out_table_full
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BW = (CW > stbi_pkg::BOUND_W) ? CW : stbi_pkg::BOUND_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SRCH = 3'b010,
    ST_WR   = 3'b100
  } state_t;

  state_t                              state_r, state_nxt;
  logic [CW-1:0]                       count_r, count_nxt;
  logic [CW-1:0]                       lo_r, lo_nxt;
  logic [CW-1:0]                       hi_r, hi_nxt;
  logic signed [stbi_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [CW-1:0]                       out_pos_r, out_pos_nxt;
  logic [CW-1:0]                       out_cnt_r, out_cnt_nxt;
  logic                                out_full_r, out_full_nxt;

  logic [CW-1:0]                       count_eff;
  logic [BW-1:0]                       bound_ext;
  logic [BW-1:0]                       last_idx;
  logic [BW-1:0]                       bound_clamp;
  logic [CW-1:0]                       mid;
  logic                                accept;

  logic signed [stbi_pkg::VALUE_W-1:0] entries [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]              less_vec;
  stbi_pkg::cell_ctl_t                 ctl [TABLE_DEPTH];

  // Build the row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic signed [stbi_pkg::VALUE_W-1:0] prev_entry;
    if (i == 0) begin : g_first
      assign prev_entry = value_r;
    end else begin : g_rest
      assign prev_entry = entries[i-1];
    end
    assign ctl[i].load     = (state_r == ST_WR) && (CW'(i) >= lo_r);
    assign ctl[i].take_new = (CW'(i) == lo_r);
    stbi_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_word   (value_r),
      .prev_entry (prev_entry),
      .entry      (entries[i]),
      .less       (less_vec[i])
    );
  end

  assign accept      = start && (state_r == ST_IDLE);
  assign count_eff   = in_start_new ? '0 : count_r;
  assign bound_ext   = BW'(in_search_bound);
  assign last_idx    = BW'(count_eff) - BW'(1);
  assign bound_clamp = (bound_ext < last_idx) ? bound_ext : last_idx;
  assign mid         = lo_r + ((hi_r - lo_r) >> 1);

  // Sequence accept, bisection and shift-insert
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_full_nxt  = out_full_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          value_nxt = in_new_value;
          count_nxt = count_eff;
          lo_nxt    = '0;
          if (count_eff >= CW'(TABLE_DEPTH)) begin
            // drop the word, report full
            out_valid_nxt = 1'b1;
            out_pos_nxt   = '0;
            out_cnt_nxt   = count_eff;
            out_full_nxt  = 1'b1;
          end else if (count_eff == '0) begin
            hi_nxt    = '0;
            state_nxt = ST_WR;
          end else begin
            hi_nxt    = CW'(bound_clamp + BW'(1));
            state_nxt = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (lo_r < hi_r) begin
          if (less_vec[mid[AW-1:0]]) begin
            lo_nxt = mid + CW'(1);
          end else begin
            hi_nxt = mid;
          end
        end else begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        count_nxt     = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_pos_nxt   = lo_r;
        out_cnt_nxt   = count_r + CW'(1);
        out_full_nxt  = 1'b0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold search bounds, word and result fields
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    value_r    <= value_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_full_r <= out_full_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_insert_position = out_pos_r;
  assign out_entry_count     = out_cnt_r;
  assign out_table_full      = out_full_r;

`include "sorted_table_bounded_insert_defines.svh"

  `STBI_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid,
                    "item accepted but no progress")
  `STBI_ASSERT_NOW(a_full_pos, out_valid && out_table_full,
                   out_insert_position == '0 && out_entry_count == CW'(TABLE_DEPTH),
                   "full result fields wrong")
  `STBI_ASSERT_NOW(a_pos_in_range, out_valid && !out_table_full,
                   out_insert_position < out_entry_count, "insert position beyond count")
  `STBI_ASSERT_NOW(a_srch_bounds, state_r == ST_SRCH, lo_r <= hi_r && hi_r <= count_r,
                   "search window out of range")

endmodule
